FILE: hw/rtl/xed_pkg.sv
// Package for the XML entity decoder: command type, character codes and entity tables.
`default_nettype none
package xed_pkg;

  localparam int unsigned EntCount  = 8;
  localparam int unsigned HoldDepth = 4;
  localparam int unsigned MaxOut    = 6;

  localparam logic [7:0] ChrAmp   = 8'h26;
  localparam logic [7:0] ChrSemi  = 8'h3b;
  localparam logic [7:0] ChrBsl   = 8'h5c;
  localparam logic [7:0] ChrQuot  = 8'h22;
  localparam logic [7:0] ChrApos  = 8'h27;

  // Entity indexes.
  typedef enum logic [2:0] {
    EntAmp  = 3'd0,
    EntLt   = 3'd1,
    EntGt   = 3'd2,
    EntQuot = 3'd3,
    EntApos = 3'd4,
    EntLf   = 3'd5,
    EntCr   = 3'd6,
    EntTab  = 3'd7
  } ent_e;

  // One burst of decoded bytes, produced by the front and played out by the back.
  typedef struct packed {
    logic [MaxOut-1:0][7:0] bytes;
    logic [2:0]             cnt;
    logic                   last;
  } xed_cmd_t;

  // Length of an entity name after the ampersand, semicolon included.
  function automatic logic [2:0] ent_len(input ent_e e);
    logic [2:0] len;
    case (e)
      EntAmp:  len = 3'd4;
      EntLt:   len = 3'd3;
      EntGt:   len = 3'd3;
      EntQuot: len = 3'd5;
      EntApos: len = 3'd5;
      default: len = 3'd4;
    endcase
    return len;
  endfunction

  // Character at a position of an entity name; positions past the end read as zero.
  function automatic logic [7:0] ent_chr(input ent_e e, input logic [2:0] pos);
    logic [4:0][7:0] name;
    logic [7:0]      chr;
    case (e)
      EntAmp:  name = {8'h00, ChrSemi, "p", "m", "a"};
      EntLt:   name = {8'h00, 8'h00, ChrSemi, "t", "l"};
      EntGt:   name = {8'h00, 8'h00, ChrSemi, "t", "g"};
      EntQuot: name = {ChrSemi, "t", "o", "u", "q"};
      EntApos: name = {ChrSemi, "s", "o", "p", "a"};
      EntLf:   name = {8'h00, ChrSemi, "A", "x", "#"};
      EntCr:   name = {8'h00, ChrSemi, "D", "x", "#"};
      default: name = {8'h00, ChrSemi, "9", "x", "#"};
    endcase
    case (pos)
      3'd0:    chr = name[0];
      3'd1:    chr = name[1];
      3'd2:    chr = name[2];
      3'd3:    chr = name[3];
      3'd4:    chr = name[4];
      default: chr = 8'h00;
    endcase
    return chr;
  endfunction

  // Decoded text of an entity: up to two bytes, first in the low byte.
  function automatic logic [1:0][7:0] ent_dec(input ent_e e);
    logic [1:0][7:0] dec;
    case (e)
      EntAmp:  dec = {8'h00, ChrAmp};
      EntLt:   dec = {8'h00, "<"};
      EntGt:   dec = {8'h00, ">"};
      EntQuot: dec = {ChrQuot, ChrBsl};
      EntApos: dec = {ChrApos, ChrBsl};
      EntLf:   dec = {8'h00, 8'h0a};
      EntCr:   dec = {8'h00, 8'h0d};
      default: dec = {8'h00, 8'h09};
    endcase
    return dec;
  endfunction

  // Number of decoded bytes of an entity.
  function automatic logic [2:0] ent_ndec(input ent_e e);
    logic [2:0] n;
    case (e)
      EntQuot: n = 3'd2;
      EntApos: n = 3'd2;
      default: n = 3'd1;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/xed_if.sv
// Stream interfaces for the encoded input and the decoded output of the decoder.
`default_nettype none
interface xed_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface xed_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/xed_front.sv
// Front end: accepts input bytes, tracks entity matching and issues output bursts.
`default_nettype none
module xed_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [7:0]        in_byte_i,
  input  wire logic              in_last_i,
  output logic                   push_o,
  input  wire logic              push_ready_i,
  output xed_pkg::xed_cmd_t      cmd_o
);
  import xed_pkg::*;

  logic                 in_ent_q, in_ent_d;
  logic [2:0]           cnt_q, cnt_d;
  logic [EntCount-1:0]  mask_q, mask_d;
  logic [7:0]           held_q [HoldDepth];
  logic                 held_we;
  logic [EntCount-1:0]  cont;
  logic [EntCount-1:0]  full_vec;
  logic [EntCount-1:0]  pre_vec;
  logic                 full;
  logic                 pre;
  ent_e                 full_idx;
  logic                 fresh_amp;
  logic                 fire;
  logic [MaxOut-1:0][7:0] seq;
  xed_cmd_t             cmd;

  assign fire       = in_valid_i && in_ready_o;
  assign in_ready_o = push_ready_i;
  assign fresh_amp  = (in_byte_i == ChrAmp) && !in_last_i;

  // Compare the new byte against the next character of each entity still in the running.
  always_comb begin
    full_idx = EntAmp;
    for (int i = 0; i < EntCount; i++) begin
      cont[i]     = mask_q[i] && (ent_len(ent_e'(3'(i))) > cnt_q) &&
                    (ent_chr(ent_e'(3'(i)), cnt_q) == in_byte_i);
      full_vec[i] = cont[i] && (ent_len(ent_e'(3'(i))) == cnt_q + 3'd1);
      pre_vec[i]  = cont[i] && (ent_len(ent_e'(3'(i))) > cnt_q + 3'd1);
    end
    for (int i = EntCount - 1; i >= 0; i--) begin
      if (full_vec[i]) full_idx = ent_e'(3'(i));
    end
    full = |full_vec;
    pre  = |pre_vec;
  end

  // Flush sequence: ampersand, the held bytes, then the current byte.
  always_comb begin
    seq[0] = ChrAmp;
    for (int j = 1; j < MaxOut; j++) begin
      if (j <= HoldDepth && 3'(j) <= cnt_q) seq[j] = held_q[2'(j-1)];
      else                                  seq[j] = in_byte_i;
    end
  end

  // Next state and the burst for the current byte.
  always_comb begin
    in_ent_d  = in_ent_q;
    cnt_d     = cnt_q;
    mask_d    = mask_q;
    held_we   = 1'b0;
    cmd.bytes = seq;
    cmd.cnt   = 3'd0;
    cmd.last  = in_last_i;
    if (in_ent_q) begin
      if (full) begin
        cmd.bytes[1:0] = ent_dec(full_idx);
        cmd.cnt        = ent_ndec(full_idx);
        in_ent_d       = 1'b0;
        cnt_d          = 3'd0;
      end else if (pre) begin
        held_we = 1'b1;
        cnt_d   = cnt_q + 3'd1;
        mask_d  = cont;
        if (in_last_i) begin
          cmd.cnt  = cnt_q + 3'd2;
          in_ent_d = 1'b0;
          cnt_d    = 3'd0;
        end
      end else if (fresh_amp) begin
        // Flush what was held and start a new match on this ampersand.
        cmd.cnt = cnt_q + 3'd1;
        cnt_d   = 3'd0;
        mask_d  = '1;
      end else begin
        cmd.cnt  = cnt_q + 3'd2;
        in_ent_d = 1'b0;
        cnt_d    = 3'd0;
      end
    end else if (fresh_amp) begin
      in_ent_d = 1'b1;
      cnt_d    = 3'd0;
      mask_d   = '1;
    end else begin
      cmd.bytes[0] = in_byte_i;
      cmd.cnt      = 3'd1;
    end
  end

  assign push_o = fire && (cmd.cnt != 3'd0);
  assign cmd_o  = cmd;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ent_q <= 1'b0;
      cnt_q    <= 3'd0;
      mask_q   <= '1;
    end else if (fire) begin
      in_ent_q <= in_ent_d;
      cnt_q    <= cnt_d;
      mask_q   <= mask_d;
    end
  end

  // Held bytes of a partial entity name.
  always_ff @(posedge clk_i) begin
    if (fire && held_we) begin
      held_q[cnt_q[1:0]] <= in_byte_i;
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'(HoldDepth))
    else $error("held count beyond hold depth");
  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && in_last_i |=> !in_ent_q && cnt_q == 3'd0)
    else $error("matcher not idle after end of string");
  a_burst_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> cmd_o.cnt <= 3'(MaxOut))
    else $error("burst longer than six bytes");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/xed_queue.sv
// Two-entry queue of output bursts between the front end and the back end.
`default_nettype none
module xed_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  output logic                   push_ready_o,
  input  xed_pkg::xed_cmd_t      push_cmd_i,
  output logic                   pop_valid_o,
  input  wire logic              pop_i,
  output xed_pkg::xed_cmd_t      pop_cmd_o
);
  import xed_pkg::*;

  xed_cmd_t   mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] fill_q;
  logic       do_push;
  logic       do_pop;

  assign push_ready_o = fill_q != 2'd2;
  assign pop_valid_o  = fill_q != 2'd0;
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_cmd_o    = mem_q[rd_ptr_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      fill_q <= fill_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_cmd_i;
  end

`ifndef SYNTHESIS
  a_fill_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == 2'd1) == (wr_ptr_q != rd_ptr_q))
    else $error("queue pointers disagree with fill level");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/xed_back.sv
// Back end: plays out each queued burst one decoded byte per cycle while the output is ready.
`default_nettype none
module xed_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              pop_valid_i,
  output logic                   pop_o,
  input  xed_pkg::xed_cmd_t      pop_cmd_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [7:0]             out_byte_o,
  output logic                   out_last_o
);
  import xed_pkg::*;

  xed_cmd_t   cur_q;
  logic       cur_vld_q;
  logic [2:0] idx_q;
  logic       fire;
  logic       last_beat;

  assign fire        = out_valid_o && out_ready_i;
  assign last_beat   = idx_q == cur_q.cnt - 3'd1;
  assign pop_o       = pop_valid_i && (!cur_vld_q || (fire && last_beat));
  assign out_valid_o = cur_vld_q;
  assign out_byte_o  = cur_q.bytes[idx_q];
  assign out_last_o  = cur_q.last && last_beat;

  // Current burst and byte position.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= 1'b0;
      idx_q     <= 3'd0;
    end else if (pop_o) begin
      cur_vld_q <= 1'b1;
      idx_q     <= 3'd0;
    end else if (fire) begin
      if (last_beat) begin
        cur_vld_q <= 1'b0;
        idx_q     <= 3'd0;
      end else begin
        idx_q <= idx_q + 3'd1;
      end
    end
  end

  // Burst payload.
  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= pop_cmd_i;
  end

`ifndef SYNTHESIS
  a_idx_in_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_vld_q |-> idx_q < cur_q.cnt)
    else $error("byte position beyond burst length");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/xml_entity_decoder.sv
// Top level of the XML entity decoder: front end, burst queue and back end.
//
//   channel  dir  payload              request moves
//   in_i     in   in_byte, in_last     one encoded byte
//   out_o    out  out_byte, out_last   one decoded byte
//
// One input request is taken per cycle while the two-entry burst queue has room.
// A byte expands into zero to six output bytes; the back end plays out one per
// cycle while the output is ready, so expansions stall the input only once the queue has filled.
// Reset is asynchronous, active low, and clears the matcher, queue and back end.
// An output stall holds the current byte stable until it is taken.
`default_nettype none
module xml_entity_decoder (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  xed_in_if.sink     in_i,
  xed_out_if.source  out_o
);
  import xed_pkg::*;

  logic     push;
  logic     push_ready;
  xed_cmd_t push_cmd;
  logic     pop_valid;
  logic     pop;
  xed_cmd_t pop_cmd;

  xed_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .in_byte_i    (in_i.in_byte),
    .in_last_i    (in_i.in_last),
    .push_o       (push),
    .push_ready_i (push_ready),
    .cmd_o        (push_cmd)
  );

  xed_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_cmd_o    (pop_cmd)
  );

  xed_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_o       (pop),
    .pop_cmd_i   (pop_cmd),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_byte_o  (out_o.out_byte),
    .out_last_o  (out_o.out_last)
  );

endmodule
`default_nettype wire

FILE: tb/xml_entity_decoder_tb.sv
// Testbench for the XML entity decoder: random byte stream, self-checking decode predictor.
module xml_entity_decoder_tb;
  import xed_pkg::*;

  localparam int unsigned RandomItems = 420;
  localparam int unsigned StuckLimit  = 2000;
  localparam int unsigned TailCycles  = 20;

  // One request on the encoded side, with a flag that holds it back until
  // all decoded bytes owed so far have been delivered.
  typedef struct {
    logic [7:0] b;
    logic       last;
    bit         drain;
  } text_req_t;

  // One decoded byte as it should appear on the output.
  typedef struct {
    logic [7:0] b;
    logic       last;
  } plain_byte_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  xed_in_if  in_bus ();
  xed_out_if out_bus ();

  xml_entity_decoder u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always #2 clk_i = ~clk_i;

  text_req_t   text_q[$];
  plain_byte_t plain_q[$];
  plain_byte_t got_want;
  text_req_t   next_req;

  // Shadow of the matcher state.
  bit          amp_open;
  logic [7:0]  held[HoldDepth];
  int          held_n;

  int          mismatches;
  int          stuck_cycles;
  int          send_gap;
  int          sink_stall;
  int          calm_left[2];
  bit          drain_next;

  // Entity names after the ampersand, semicolon included.
  function automatic string entity_name(input ent_e e);
    case (e)
      EntAmp:  return "amp;";
      EntLt:   return "lt;";
      EntGt:   return "gt;";
      EntQuot: return "quot;";
      EntApos: return "apos;";
      EntLf:   return "#xA;";
      EntCr:   return "#xD;";
      default: return "#x9;";
    endcase
  endfunction

  // Decoded text of each entity; the quote entities come out escaped.
  function automatic void entity_expand(input ent_e e, output logic [7:0] d0,
                                        output logic [7:0] d1, output int nd);
    d1 = 8'h00;
    nd = 1;
    case (e)
      EntAmp:  d0 = ChrAmp;
      EntLt:   d0 = "<";
      EntGt:   d0 = ">";
      EntQuot: begin
        d0 = ChrBsl;
        d1 = ChrQuot;
        nd = 2;
      end
      EntApos: begin
        d0 = ChrBsl;
        d1 = ChrApos;
        nd = 2;
      end
      EntLf:   d0 = 8'h0a;
      EntCr:   d0 = 8'h0d;
      default: d0 = 8'h09;
    endcase
  endfunction

  // Work out the decoded bytes that one accepted input byte releases.
  function automatic void decode_byte(input logic [7:0] b, input logic last);
    logic [7:0]  res[MaxOut];
    logic [7:0]  cand[HoldDepth+1];
    logic [7:0]  d0;
    logic [7:0]  d1;
    int          nres;
    int          n;
    int          full;
    int          nd;
    int          i;
    int          e;
    bit          pre;
    bit          same;
    bit          fresh;
    string       nm;
    plain_byte_t pb;
    nres  = 0;
    fresh = 1'b1;
    if (amp_open) begin
      n = held_n;
      for (i = 0; i < n; i++) cand[i] = held[i];
      cand[n] = b;
      full  = -1;
      pre   = 1'b0;
      fresh = 1'b0;
      for (e = 0; e < EntCount; e++) begin
        nm = entity_name(ent_e'(e));
        if (nm.len() >= n + 1) begin
          same = 1'b1;
          for (i = 0; i <= n; i++) if (nm[i] != cand[i]) same = 1'b0;
          if (same && nm.len() == n + 1) full = e;
          else if (same) pre = 1'b1;
        end
      end
      if (full >= 0) begin
        entity_expand(ent_e'(full), d0, d1, nd);
        res[nres] = d0;
        nres++;
        if (nd == 2) begin
          res[nres] = d1;
          nres++;
        end
        amp_open = 1'b0;
        held_n   = 0;
      end else if (pre && n + 1 <= HoldDepth) begin
        held[n] = b;
        held_n  = n + 1;
        // The string ends inside a possible entity: flush it as plain text.
        if (last) begin
          res[nres] = ChrAmp;
          nres++;
          for (i = 0; i <= n; i++) begin
            res[nres] = held[i];
            nres++;
          end
          amp_open = 1'b0;
          held_n   = 0;
        end
      end else begin
        res[nres] = ChrAmp;
        nres++;
        for (i = 0; i < n; i++) begin
          res[nres] = held[i];
          nres++;
        end
        amp_open = 1'b0;
        held_n   = 0;
        fresh    = 1'b1;
      end
    end
    // A byte not absorbed by a pending entity is looked at on its own.
    if (fresh) begin
      if (b == ChrAmp && !last) begin
        amp_open = 1'b1;
        held_n   = 0;
      end else begin
        res[nres] = b;
        nres++;
      end
    end
    if (last) begin
      amp_open = 1'b0;
      held_n   = 0;
    end
    for (i = 0; i < nres; i++) begin
      pb.b    = res[i];
      pb.last = last && (i == nres - 1);
      plain_q.insert(plain_q.size(), pb);
    end
  endfunction

  // Idle length for one side: mostly short, a few long, with calm stretches.
  function automatic int gap_len(input int side);
    int r;
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm_left[side] = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  task automatic flag_mismatch(input string what, input logic [7:0] got,
                               input logic [7:0] want);
    $display("[%0t] %s: got 0x%02h, want 0x%02h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic push_byte(input logic [7:0] b, input logic last);
    text_req_t r;
    r.b        = b;
    r.last     = last;
    r.drain    = drain_next;
    drain_next = 1'b0;
    text_q.insert(text_q.size(), r);
  endtask

  // Queue a piece of text; the last flag goes on its final byte if asked.
  task automatic push_text(input string s, input bit last_at_end);
    int i;
    for (i = 0; i < s.len(); i++) push_byte(s[i], last_at_end && (i == s.len() - 1));
  endtask

  // Random strings built mostly from well-formed entities, with broken
  // prefixes and plain or near-miss bytes mixed in.
  task automatic build_random_text();
    logic [7:0] seg[$];
    string      alpha;
    string      nm;
    int         nseg;
    int         s;
    int         kind;
    int         cut;
    int         cnt;
    int         i;
    alpha = "amplgtquosx#AD9;&";
    while (text_q.size() < RandomItems + 22) begin
      nseg = $urandom_range(1, 6);
      for (s = 0; s < nseg; s++) begin
        seg.delete();
        kind = $urandom_range(0, 99);
        nm   = entity_name(ent_e'($urandom_range(0, EntCount - 1)));
        if (kind < 45) begin
          seg.insert(seg.size(), ChrAmp);
          for (i = 0; i < nm.len(); i++) seg.insert(seg.size(), nm[i]);
        end else if (kind < 62) begin
          cut = $urandom_range(0, nm.len() - 1);
          seg.insert(seg.size(), ChrAmp);
          for (i = 0; i < cut; i++) seg.insert(seg.size(), nm[i]);
          if ($urandom_range(0, 1)) seg.insert(seg.size(), 8'($urandom_range(0, 255)));
        end else begin
          cnt = $urandom_range(1, 4);
          for (i = 0; i < cnt; i++) begin
            kind = $urandom_range(0, 3);
            if (kind == 0) seg.insert(seg.size(), ChrAmp);
            else if (kind == 1)
              seg.insert(seg.size(), alpha[$urandom_range(0, alpha.len() - 1)]);
            else seg.insert(seg.size(), 8'($urandom_range(0, 255)));
          end
        end
        if ($urandom_range(0, 29) == 0) drain_next = 1'b1;
        for (i = 0; i < seg.size(); i++)
          push_byte(seg[i], (s == nseg - 1) && (i == seg.size() - 1));
      end
    end
  endtask

  // Sender: offers one request at a time from the pending text.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_bus.valid && in_bus.ready) decode_byte(in_bus.in_byte, in_bus.in_last);
      if (!in_bus.valid || in_bus.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_bus.valid <= 1'b0;
        end else if (text_q.size() > 0 && !(text_q[0].drain && plain_q.size() > 0)) begin
          next_req = text_q.pop_front();
          in_bus.valid   <= 1'b1;
          in_bus.in_byte <= next_req.b;
          in_bus.in_last <= next_req.last;
          send_gap = gap_len(0);
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each decoded byte against the oldest one owed.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_bus.valid && out_bus.ready) begin
        if (plain_q.size() == 0) begin
          flag_mismatch("decoded byte with none owed", out_bus.out_byte, 8'h00);
        end else begin
          got_want = plain_q.pop_front();
          if (out_bus.out_byte !== got_want.b)
            flag_mismatch("out_byte", out_bus.out_byte, got_want.b);
          if (out_bus.out_last !== got_want.last)
            flag_mismatch("out_last", {7'd0, out_bus.out_last}, {7'd0, got_want.last});
        end
      end
      if (sink_stall > 0) begin
        sink_stall--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
        sink_stall = gap_len(1);
      end
    end
  end

  // Count cycles in which neither side moves a request.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
        stuck_cycles <= 0;
      else
        stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    wait (stuck_cycles >= StuckLimit);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst_ni         = 1'b0;
    in_bus.valid   = 1'b0;
    in_bus.in_byte = 8'h00;
    in_bus.in_last = 1'b0;
    out_bus.ready  = 1'b0;
    amp_open       = 1'b0;
    held_n         = 0;
    mismatches     = 0;
    stuck_cycles   = 0;
    send_gap       = 0;
    sink_stall     = 0;
    calm_left[0]   = 0;
    calm_left[1]   = 0;
    drain_next     = 1'b0;

    // Directed text: byte extremes, a quote entity, a six-byte mismatch flush,
    // an ampersand restarting a match, end of string inside a prefix, and a
    // lone ampersand as the final byte.
    push_byte(8'h00, 1'b0);
    push_byte(8'hff, 1'b1);
    push_text("&quot;", 1'b0);
    push_text("&aposZ", 1'b0);
    push_text("&&gt;", 1'b1);
    push_text("&l", 1'b1);
    push_text("&", 1'b1);

    drain_next = 1'b1;
    build_random_text();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (text_q.size() > 0 || in_bus.valid || plain_q.size() > 0) @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: xml_entity_decoder.f
hw/rtl/xed_pkg.sv
hw/rtl/xed_if.sv
hw/rtl/xed_front.sv
hw/rtl/xed_queue.sv
hw/rtl/xed_back.sv
hw/rtl/xml_entity_decoder.sv
tb/xml_entity_decoder_tb.sv
